[rtl/core/rod_distance_constraint_solver_unit_defines.svh]
// ----------------------------------------------------------------------------
// Rod distance constraint solver: assertion macros
// Concurrent checks used inside the solver RTL; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ROD_DISTANCE_CONSTRAINT_SOLVER_UNIT_DEFINES_SVH
`define ROD_DISTANCE_CONSTRAINT_SOLVER_UNIT_DEFINES_SVH

`ifndef SYNTH
// implication or plain property, checked on every clock edge out of reset
`define RDCS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("rdcs assertion failed");
// condition that must never be seen out of reset
`define RDCS_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("rdcs forbidden condition");
`else
`define RDCS_ASSERT(lbl, clk, rstn, prop)
`define RDCS_NEVER(lbl, clk, rstn, expr)
`endif

`endif

[rtl/core/rdcs_pkg.sv]
// ----------------------------------------------------------------------------
// Rod distance constraint solver package
// Widths, status codes, register indexes and pipeline payload types.
// ----------------------------------------------------------------------------
package rdcs_pkg;

  localparam int POS_W   = 32;
  localparam int MASS_W  = 32;
  localparam int LEN_W   = 32;
  localparam int TOL_W   = 16;
  localparam int SUM_W   = 33;
  localparam int SQ_W    = 64;
  localparam int D2_W    = 65;
  localparam int ROOT_W  = 33;
  localparam int PROD_W  = 65;
  localparam int SHIFT_W = 35;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROD_LEN    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_TOL = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_AT_LEN     = 2'd1,
    ST_NO_MASS    = 2'd2,
    ST_COINCIDENT = 2'd3
  } status_t;

  // per-rod data carried along the whole pipe
  typedef struct packed {
    logic signed [POS_W-1:0] x1;
    logic signed [POS_W-1:0] y1;
    logic signed [POS_W-1:0] x2;
    logic signed [POS_W-1:0] y2;
    logic [MASS_W-1:0]       m1;
    logic [MASS_W-1:0]       m2;
    logic [SUM_W-1:0]        msum;
    logic [POS_W-1:0]        ax;
    logic [POS_W-1:0]        ay;
    logic                    dx_neg;
    logic                    dy_neg;
    status_t                 status;
  } side_t;

  // side data through the mass divider
  typedef struct packed {
    side_t             side;
    logic [ROOT_W-1:0] root;
    logic              neg;
  } mid_t;

  // side data through the direction divider
  typedef struct packed {
    side_t side;
    logic  neg;
  } tail_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] res;
    if (v > 36'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

[rtl/core/rdcs_in_if.sv]
// ----------------------------------------------------------------------------
// Rod input channel
// Two end positions and two end masses per transaction.
// ----------------------------------------------------------------------------
interface rdcs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic [31:0]        end1_mass;
  logic [31:0]        end2_mass;

  modport source (
    output valid, first_x, first_y, second_x, second_y, end1_mass, end2_mass,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, second_x, second_y, end1_mass, end2_mass,
    output ready
  );
endinterface

[rtl/core/rdcs_out_if.sv]
// ----------------------------------------------------------------------------
// Rod result channel
// Displacements, corrected positions and status per transaction.
// ----------------------------------------------------------------------------
interface rdcs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_shift_x;
  logic signed [31:0] first_shift_y;
  logic signed [31:0] second_shift_x;
  logic signed [31:0] second_shift_y;
  logic signed [31:0] new_first_x;
  logic signed [31:0] new_first_y;
  logic signed [31:0] new_second_x;
  logic signed [31:0] new_second_y;
  logic [1:0]         status;

  modport source (
    output valid, first_shift_x, first_shift_y, second_shift_x, second_shift_y,
           new_first_x, new_first_y, new_second_x, new_second_y, status,
    input  ready
  );
  modport sink (
    input  valid, first_shift_x, first_shift_y, second_shift_x, second_shift_y,
           new_first_x, new_first_y, new_second_x, new_second_y, status,
    output ready
  );
endinterface

[rtl/core/rdcs_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data per transaction.
// ----------------------------------------------------------------------------
interface rdcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/rdcs_sqrt_pipe.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, restoring digit recurrence, side data travels along.
// ----------------------------------------------------------------------------
module rdcs_sqrt_pipe #(
  parameter int RW     = 33,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  logic [SIDE_W-1:0] in_side,
  input  logic [2*RW-1:0]   in_rad,
  output logic              out_vld,
  output logic [SIDE_W-1:0] out_side,
  output logic [RW-1:0]     out_root
);

  logic              vld_r  [RW];
  logic [SIDE_W-1:0] side_r [RW];
  logic [RW:0]       rem_r  [RW];
  logic [RW-1:0]     root_r [RW];
  logic [2*RW-1:0]   rad_r  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic              src_vld;
    logic [SIDE_W-1:0] src_side;
    logic [RW:0]       src_rem;
    logic [RW-1:0]     src_root;
    logic [2*RW-1:0]   src_rad;
    logic [RW+2:0]     temp;
    logic [RW+2:0]     trial;
    logic [RW+2:0]     diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign src_vld  = in_vld;
      assign src_side = in_side;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_rad  = in_rad;
    end else begin : g_next
      assign src_vld  = vld_r[k-1];
      assign src_side = side_r[k-1];
      assign src_rem  = rem_r[k-1];
      assign src_root = root_r[k-1];
      assign src_rad  = rad_r[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign temp  = {src_rem, src_rad[2*RW-1 -: 2]};
    assign trial = {1'b0, src_root, 2'b01};
    assign ge    = (temp >= trial);
    assign diff  = temp - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[k] <= src_side;
        rem_r[k]  <= ge ? diff[RW:0] : temp[RW:0];
        root_r[k] <= {src_root[RW-2:0], ge};
        rad_r[k]  <= {src_rad[2*RW-3:0], 2'b00};
      end
    end
  end

  assign out_vld  = vld_r[RW-1];
  assign out_side = side_r[RW-1];
  assign out_root = root_r[RW-1];

endmodule

[rtl/core/rdcs_div_pipe.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider, several lanes in lockstep
// One quotient bit per stage; quotient must fit in QBITS bits.
// ----------------------------------------------------------------------------
module rdcs_div_pipe #(
  parameter int LANES  = 2,
  parameter int DEN_W  = 33,
  parameter int QBITS  = 33,
  parameter int SIDE_W = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_vld,
  input  logic [SIDE_W-1:0]      in_side,
  input  logic [DEN_W+QBITS-2:0] in_num [LANES],
  input  logic [DEN_W-1:0]       in_den [LANES],
  output logic                   out_vld,
  output logic [SIDE_W-1:0]      out_side,
  output logic [QBITS-1:0]       out_q  [LANES]
);

  localparam int NUM_W = DEN_W + QBITS - 1;

  logic              vld_r  [QBITS];
  logic [SIDE_W-1:0] side_r [QBITS];
  logic [DEN_W-1:0]  rem_r  [QBITS][LANES];
  logic [QBITS-1:0]  low_r  [QBITS][LANES];
  logic [QBITS-1:0]  q_r    [QBITS][LANES];
  logic [DEN_W-1:0]  den_r  [QBITS][LANES];

  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    logic              src_vld;
    logic [SIDE_W-1:0] src_side;
    logic [DEN_W-1:0]  src_rem [LANES];
    logic [QBITS-1:0]  src_low [LANES];
    logic [QBITS-1:0]  src_q   [LANES];
    logic [DEN_W-1:0]  src_den [LANES];
    logic [DEN_W:0]    t       [LANES];
    logic [DEN_W:0]    diff    [LANES];
    logic              ge      [LANES];

    if (k == 0) begin : g_first
      assign src_vld  = in_vld;
      assign src_side = in_side;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign src_rem[l] = {1'b0, in_num[l][NUM_W-1:QBITS]};
        assign src_low[l] = in_num[l][QBITS-1:0];
        assign src_q[l]   = '0;
        assign src_den[l] = in_den[l];
      end
    end else begin : g_next
      assign src_vld  = vld_r[k-1];
      assign src_side = side_r[k-1];
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign src_rem[l] = rem_r[k-1][l];
        assign src_low[l] = low_r[k-1][l];
        assign src_q[l]   = q_r[k-1][l];
        assign src_den[l] = den_r[k-1][l];
      end
    end

    // shift in next dividend bit, subtract divisor when it fits
    for (genvar l = 0; l < LANES; l++) begin : g_calc
      assign t[l]    = {src_rem[l], src_low[l][QBITS-1]};
      assign ge[l]   = (t[l] >= {1'b0, src_den[l]});
      assign diff[l] = t[l] - {1'b0, src_den[l]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[k] <= src_side;
        for (int l = 0; l < LANES; l++) begin
          rem_r[k][l] <= ge[l] ? diff[l][DEN_W-1:0] : t[l][DEN_W-1:0];
          low_r[k][l] <= {src_low[l][QBITS-2:0], 1'b0};
          q_r[k][l]   <= {src_q[l][QBITS-2:0], ge[l]};
          den_r[k][l] <= src_den[l];
        end
      end
    end
  end

  assign out_vld  = vld_r[QBITS-1];
  assign out_side = side_r[QBITS-1];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign out_q[l] = q_r[QBITS-1][l];
  end

endmodule

[rtl/core/rod_distance_constraint_solver_unit.sv]
// ----------------------------------------------------------------------------
// Rod distance constraint solver
// Pipeline from input transaction to result valid: 5 front stages,
//   33-stage square root, 2 stages, 33-stage mass divider, 1 stage,
//   33-stage direction divider, 2 output stages.
// Throughput: one rod per cycle; the whole pipe holds while a result waits.
// Reset: synchronous active low; clears valid bits, rod length to 0 and
//   length_tolerance to 1. No clearing pass.
// ----------------------------------------------------------------------------
`include "rod_distance_constraint_solver_unit_defines.svh"

module rod_distance_constraint_solver_unit import rdcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rdcs_cfg_if.sink    cfg_wr,
  rdcs_in_if.sink     in_rod,
  rdcs_out_if.source  out_rod
);

  // configuration registers
  logic [LEN_W-1:0] rod_len_r;
  logic [TOL_W-1:0] length_tol_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rod_len_r    <= '0;
      length_tol_r <= 16'd1;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_ROD_LEN:    rod_len_r    <= cfg_wr.data;
        REG_LENGTH_TOL: length_tol_r <= cfg_wr.data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: pipe moves unless a result is held
  logic adv;
  logic out_vld_r;

  assign adv          = !out_vld_r || out_rod.ready;
  assign in_rod.ready = adv;

  // stage 1: differences, absolute values, mass sum, squared length
  logic signed [POS_W:0] dx_s, dy_s;
  logic [POS_W:0]        ax_w, ay_w;
  side_t                 p1_side_nxt;
  logic                  p1_vld_r;
  side_t                 p1_side_r;
  logic [SQ_W-1:0]       p1_l2_r;

  assign dx_s = {in_rod.first_x[31], in_rod.first_x} - {in_rod.second_x[31], in_rod.second_x};
  assign dy_s = {in_rod.first_y[31], in_rod.first_y} - {in_rod.second_y[31], in_rod.second_y};
  assign ax_w = dx_s[POS_W] ? -dx_s : dx_s;
  assign ay_w = dy_s[POS_W] ? -dy_s : dy_s;

  always_comb begin
    p1_side_nxt.x1     = in_rod.first_x;
    p1_side_nxt.y1     = in_rod.first_y;
    p1_side_nxt.x2     = in_rod.second_x;
    p1_side_nxt.y2     = in_rod.second_y;
    p1_side_nxt.m1     = in_rod.end1_mass;
    p1_side_nxt.m2     = in_rod.end2_mass;
    p1_side_nxt.msum   = {1'b0, in_rod.end1_mass} + {1'b0, in_rod.end2_mass};
    p1_side_nxt.ax     = ax_w[POS_W-1:0];
    p1_side_nxt.ay     = ay_w[POS_W-1:0];
    p1_side_nxt.dx_neg = dx_s[POS_W];
    p1_side_nxt.dy_neg = dy_s[POS_W];
    p1_side_nxt.status = ST_DONE;
  end

  // stage 2: squares
  logic            p2_vld_r;
  side_t           p2_side_r;
  logic [SQ_W-1:0] p2_sx_r, p2_sy_r, p2_l2_r;

  // stage 3: squared distance
  logic            p3_vld_r;
  side_t           p3_side_r;
  logic [D2_W-1:0] p3_d2_r;
  logic [SQ_W-1:0] p3_l2_r;

  // stage 4: absolute difference of squared distance and squared length
  logic            p4_vld_r;
  side_t           p4_side_r;
  logic [D2_W-1:0] p4_d2_r;
  logic [SQ_W-1:0] p4_adiff_r;

  // stage 5: classification
  logic            p5_vld_r;
  side_t           p5_side_r;
  side_t           p5_side_nxt;
  logic [D2_W-1:0] p5_d2_r;
  status_t         status_nxt;

  always_comb begin
    if (!p4_d2_r[D2_W-1] && (p4_adiff_r <= SQ_W'(length_tol_r))) begin
      status_nxt = ST_AT_LEN;
    end else if (p4_side_r.msum == '0) begin
      status_nxt = ST_NO_MASS;
    end else if (p4_d2_r == '0) begin
      status_nxt = ST_COINCIDENT;
    end else begin
      status_nxt = ST_DONE;
    end
  end

  always_comb begin
    p5_side_nxt        = p4_side_r;
    p5_side_nxt.status = status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      p4_vld_r <= 1'b0;
      p5_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= in_rod.valid;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      p4_vld_r <= p3_vld_r;
      p5_vld_r <= p4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_side_r  <= p1_side_nxt;
      p1_l2_r    <= SQ_W'(rod_len_r) * SQ_W'(rod_len_r);
      p2_side_r  <= p1_side_r;
      p2_sx_r    <= SQ_W'(p1_side_r.ax) * SQ_W'(p1_side_r.ax);
      p2_sy_r    <= SQ_W'(p1_side_r.ay) * SQ_W'(p1_side_r.ay);
      p2_l2_r    <= p1_l2_r;
      p3_side_r  <= p2_side_r;
      p3_d2_r    <= {1'b0, p2_sx_r} + {1'b0, p2_sy_r};
      p3_l2_r    <= p2_l2_r;
      p4_side_r  <= p3_side_r;
      p4_d2_r    <= p3_d2_r;
      p4_adiff_r <= (p3_d2_r[SQ_W-1:0] >= p3_l2_r) ? (p3_d2_r[SQ_W-1:0] - p3_l2_r)
                                                    : (p3_l2_r - p3_d2_r[SQ_W-1:0]);
      p5_side_r  <= p5_side_nxt;
      p5_d2_r    <= p4_d2_r;
    end
  end

  // square root of the squared distance
  logic              sq_vld;
  logic [$bits(side_t)-1:0] sq_side_bits;
  side_t             sq_side;
  logic [ROOT_W-1:0] sq_root;

  rdcs_sqrt_pipe #(
    .RW     (ROOT_W),
    .SIDE_W ($bits(side_t))
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (p5_vld_r),
    .in_side  (p5_side_r),
    .in_rad   ({1'b0, p5_d2_r}),
    .out_vld  (sq_vld),
    .out_side (sq_side_bits),
    .out_root (sq_root)
  );

  assign sq_side = sq_side_bits;

  // stage 6: length error and its sign
  logic              p6_vld_r;
  side_t             p6_side_r;
  logic [ROOT_W-1:0] p6_root_r;
  logic [ROOT_W-1:0] p6_corr_r;
  logic              p6_neg_r;
  logic              neg_w;

  assign neg_w = (sq_root > {1'b0, rod_len_r});

  // stage 7: error times each mass
  logic              p7_vld_r;
  mid_t              p7_mid_r;
  logic [PROD_W-1:0] p7_prod_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p6_vld_r <= 1'b0;
      p7_vld_r <= 1'b0;
    end else if (adv) begin
      p6_vld_r <= sq_vld;
      p7_vld_r <= p6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p6_side_r     <= sq_side;
      p6_root_r     <= sq_root;
      p6_neg_r      <= neg_w;
      p6_corr_r     <= neg_w ? (sq_root - {1'b0, rod_len_r})
                             : ({1'b0, rod_len_r} - sq_root);
      p7_mid_r.side <= p6_side_r;
      p7_mid_r.root <= p6_root_r;
      p7_mid_r.neg  <= p6_neg_r;
      p7_prod_r[0]  <= PROD_W'(p6_corr_r) * PROD_W'(p6_side_r.m1);
      p7_prod_r[1]  <= PROD_W'(p6_corr_r) * PROD_W'(p6_side_r.m2);
    end
  end

  // per-end magnitude: error * own mass / mass sum
  logic              da_vld;
  logic [$bits(mid_t)-1:0] da_side_bits;
  mid_t              da_mid;
  logic [SUM_W-1:0]  da_den [2];
  logic [ROOT_W-1:0] da_q   [2];

  assign da_den[0] = p7_mid_r.side.msum;
  assign da_den[1] = p7_mid_r.side.msum;

  rdcs_div_pipe #(
    .LANES  (2),
    .DEN_W  (SUM_W),
    .QBITS  (ROOT_W),
    .SIDE_W ($bits(mid_t))
  ) u_div_mass (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (p7_vld_r),
    .in_side  (p7_mid_r),
    .in_num   (p7_prod_r),
    .in_den   (da_den),
    .out_vld  (da_vld),
    .out_side (da_side_bits),
    .out_q    (da_q)
  );

  assign da_mid = da_side_bits;

  // stage 8: magnitude times each direction component
  logic              p8_vld_r;
  tail_t             p8_tail_r;
  logic [ROOT_W-1:0] p8_root_r;
  logic [PROD_W-1:0] p8_prod_r [4];
  logic [ROOT_W-1:0] p8_den    [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p8_vld_r <= 1'b0;
    end else if (adv) begin
      p8_vld_r <= da_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p8_tail_r.side <= da_mid.side;
      p8_tail_r.neg  <= da_mid.neg;
      p8_root_r      <= da_mid.root;
      p8_prod_r[0]   <= PROD_W'(da_q[0]) * PROD_W'(da_mid.side.ax);
      p8_prod_r[1]   <= PROD_W'(da_q[0]) * PROD_W'(da_mid.side.ay);
      p8_prod_r[2]   <= PROD_W'(da_q[1]) * PROD_W'(da_mid.side.ax);
      p8_prod_r[3]   <= PROD_W'(da_q[1]) * PROD_W'(da_mid.side.ay);
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_dden
    assign p8_den[i] = p8_root_r;
  end

  // component: product / distance
  logic              db_vld;
  logic [$bits(tail_t)-1:0] db_side_bits;
  tail_t             db_tail;
  logic [ROOT_W-1:0] db_q [4];

  rdcs_div_pipe #(
    .LANES  (4),
    .DEN_W  (ROOT_W),
    .QBITS  (ROOT_W),
    .SIDE_W ($bits(tail_t))
  ) u_div_dir (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (p8_vld_r),
    .in_side  (p8_tail_r),
    .in_num   (p8_prod_r),
    .in_den   (p8_den),
    .out_vld  (db_vld),
    .out_side (db_side_bits),
    .out_q    (db_q)
  );

  assign db_tail = db_side_bits;

  // stage 9: apply signs, zero the shifts for the special cases
  logic                      p9_vld_r;
  side_t                     p9_side_r;
  logic signed [SHIFT_W-1:0] p9_sh_r   [4];
  logic signed [SHIFT_W-1:0] sh_mag    [4];
  logic                      flip      [4];

  assign flip[0] = db_tail.neg != db_tail.side.dx_neg;
  assign flip[1] = db_tail.neg != db_tail.side.dy_neg;
  assign flip[2] = db_tail.neg == db_tail.side.dx_neg;
  assign flip[3] = db_tail.neg == db_tail.side.dy_neg;

  for (genvar i = 0; i < 4; i++) begin : g_mag
    assign sh_mag[i] = {2'b00, db_q[i]};
  end

  // stage 10: saturate shifts and corrected positions
  logic signed [POS_W-1:0] out_sh_r  [4];
  logic signed [POS_W-1:0] out_pos_r [4];
  status_t                 out_status_r;
  logic signed [POS_W-1:0] p9_pos    [4];

  assign p9_pos[0] = p9_side_r.x1;
  assign p9_pos[1] = p9_side_r.y1;
  assign p9_pos[2] = p9_side_r.x2;
  assign p9_pos[3] = p9_side_r.y2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p9_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      p9_vld_r  <= db_vld;
      out_vld_r <= p9_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p9_side_r    <= db_tail.side;
      for (int i = 0; i < 4; i++) begin
        if (db_tail.side.status != ST_DONE) begin
          p9_sh_r[i] <= '0;
        end else begin
          p9_sh_r[i] <= flip[i] ? -sh_mag[i] : sh_mag[i];
        end
        out_sh_r[i]  <= sat32({p9_sh_r[i][SHIFT_W-1], p9_sh_r[i]});
        out_pos_r[i] <= sat32({{4{p9_pos[i][POS_W-1]}}, p9_pos[i]}
                              + {p9_sh_r[i][SHIFT_W-1], p9_sh_r[i]});
      end
      out_status_r <= p9_side_r.status;
    end
  end

  assign out_rod.valid          = out_vld_r;
  assign out_rod.first_shift_x  = out_sh_r[0];
  assign out_rod.first_shift_y  = out_sh_r[1];
  assign out_rod.second_shift_x = out_sh_r[2];
  assign out_rod.second_shift_y = out_sh_r[3];
  assign out_rod.new_first_x    = out_pos_r[0];
  assign out_rod.new_first_y    = out_pos_r[1];
  assign out_rod.new_second_x   = out_pos_r[2];
  assign out_rod.new_second_y   = out_pos_r[3];
  assign out_rod.status         = out_status_r;

  // terms for the checks below
  logic shift_any;
  logic x_same_dir;

  assign shift_any  = |{out_sh_r[0], out_sh_r[1], out_sh_r[2], out_sh_r[3]};
  assign x_same_dir = (p9_sh_r[0] > 0 && p9_sh_r[2] > 0) || (p9_sh_r[0] < 0 && p9_sh_r[2] < 0);

  // no displacement unless the rod was corrected
  `RDCS_ASSERT(a_zero_shift, clk, rst_n, (out_vld_r && out_status_r != ST_DONE) |-> !shift_any)
  // the two ends never move the same way along x
  `RDCS_NEVER(a_x_opposite, clk, rst_n, p9_vld_r && p9_side_r.status == ST_DONE && x_same_dir)
  // a corrected rod always has a nonzero distance divisor
  `RDCS_ASSERT(a_root_nonzero, clk, rst_n, (p6_vld_r && p6_side_r.status == ST_DONE) |-> |p6_root_r)

endmodule
